/* hdl/caseless_multi_pattern_matcher_core_defines.svh */
// ---------------------------------------------------------------------------
// caseless multi-pattern matcher assertion macros
// shared assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef CASELESS_MULTI_PATTERN_MATCHER_CORE_DEFINES_SVH
`define CASELESS_MULTI_PATTERN_MATCHER_CORE_DEFINES_SVH

// checked only out of reset
`define CMM_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("cmm assertion failed");

// checked in every cycle, reset included
`define CMM_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("cmm assertion failed");

`endif

/* hdl/cmm_pkg.sv */
// ---------------------------------------------------------------------------
// cmm_pkg
// types and helpers shared by the caseless multi-pattern matcher
// ---------------------------------------------------------------------------
package cmm_pkg;

   typedef enum logic [1:0] {
      CMD_MSG = 2'd0,
      CMD_PAT = 2'd1,
      CMD_END = 2'd2,
      CMD_CLR = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data;
      logic       last;
   } item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] b);
      if (b >= 8'h41 && b <= 8'h5a) begin
         return b + 8'h20;
      end
      return b;
   endfunction

endpackage

/* hdl/cmm_ram.sv */
// ---------------------------------------------------------------------------
// cmm_ram
// simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module cmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/cmm_front.sv */
// ---------------------------------------------------------------------------
// cmm_front
// accepts requests, decodes and folds them, and queues them for the back end
// ---------------------------------------------------------------------------
module cmm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_start,
   input  logic [1:0]        req_mode,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last,
   output logic              busy,
   output logic              q_empty,
   output cmm_pkg::item_type q_head,
   input  logic              q_pop
);
   import cmm_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   item_type   item_in;

   always_comb begin
      item_in.cmd  = cmd_type'(req_mode);
      item_in.data = fold_byte(req_data_byte);
      item_in.last = req_last;
   end

   assign busy    = (cnt_ff == 2'd2);
   assign q_empty = (cnt_ff == 2'd0);
   assign q_head  = entry_ff[rd_ptr_ff];
   assign push    = req_start && !busy;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + (push ? 2'd1 : 2'd0) - (q_pop ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

/* hdl/cmm_back.sv */
// ---------------------------------------------------------------------------
// cmm_back
// loads the pattern table and walks every loaded pattern once per scanned message byte
// ---------------------------------------------------------------------------
module cmm_back #(
   parameter int NUM_PATTERNS  = 16,
   parameter int PATTERN_BYTES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  cmm_pkg::item_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   output logic              rsp_found
);
   import cmm_pkg::*;

   localparam int CW  = $clog2(NUM_PATTERNS + 1);
   localparam int AW  = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
   localparam int LW  = $clog2(PATTERN_BYTES + 1);
   localparam int PW  = PATTERN_BYTES * 8;
   localparam int RW  = PW + LW;

   state_type state_ff, state_in;

   logic [CW-1:0]  count_ff, valid_cnt_ff, p_ff;
   logic [LW-1:0]  wp_ff, len_ff;
   logic           zseen_ff, empty_ff, found_ff, ended_ff;
   logic [PW-1:0]  stage_ff;
   logic [7:0]     byte_ff;
   logic           last_ff;
   logic           rdv_ff, fresh_ff;
   logic [AW-1:0]  rdp_ff;
   logic           rsp_valid_ff, rsp_found_ff;

   logic [RW-1:0]            pat_rd;
   logic [PATTERN_BYTES-1:0] vec_rd, vec_old, nv;
   logic [PATTERN_BYTES:0]   vfull;
   logic [LW-1:0]            plen;
   logic                     hit;
   logic                     room;
   logic                     pat_wr;
   logic                     start_scan;

   assign room  = (count_ff < CW'(NUM_PATTERNS));
   assign q_pop = (state_ff == ST_IDLE) && !q_empty;

   always_comb begin
      start_scan = q_pop && (q_head.cmd == CMD_MSG) && !ended_ff
                   && (q_head.data != 8'd0) && (count_ff != '0);
      pat_wr = q_pop && (q_head.cmd == CMD_END) && room;
   end

   cmm_ram #(.WIDTH(RW), .DEPTH(NUM_PATTERNS), .AW(AW)) u_pat_ram (
      .clock  (clock),
      .wr_en  (pat_wr),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data({len_ff, stage_ff}),
      .rd_addr(p_ff[AW-1:0]),
      .rd_data(pat_rd)
   );

   cmm_ram #(.WIDTH(PATTERN_BYTES), .DEPTH(NUM_PATTERNS), .AW(AW)) u_vec_ram (
      .clock  (clock),
      .wr_en  (rdv_ff),
      .wr_addr(rdp_ff),
      .wr_data(nv),
      .rd_addr(p_ff[AW-1:0]),
      .rd_data(vec_rd)
   );

   // shift-and step for one pattern
   always_comb begin
      plen    = pat_rd[PW +: LW];
      vec_old = fresh_ff ? vec_rd : '0;
      vfull   = {vec_old, 1'b1};
      hit     = 1'b0;
      for (int j = 0; j < PATTERN_BYTES; j++) begin
         nv[j] = vfull[j] && (pat_rd[j*8 +: 8] == byte_ff) && (LW'(j) < plen);
         if (nv[j] && (plen == LW'(j + 1))) begin
            hit = 1'b1;
         end
      end
      hit = hit && rdv_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_scan) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (p_ff == count_ff - CW'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         valid_cnt_ff <= '0;
         p_ff         <= '0;
         wp_ff        <= '0;
         len_ff       <= '0;
         zseen_ff     <= 1'b0;
         empty_ff     <= 1'b0;
         found_ff     <= 1'b0;
         ended_ff     <= 1'b0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= (state_ff == ST_SCAN);
         case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  case (q_head.cmd)
                     CMD_MSG: begin
                        if (start_scan) begin
                           p_ff    <= '0;
                           byte_ff <= q_head.data;
                           last_ff <= q_head.last;
                        end else if (q_head.last) begin
                           rsp_valid_ff <= 1'b1;
                           rsp_found_ff <= found_ff || empty_ff;
                           found_ff     <= 1'b0;
                           ended_ff     <= 1'b0;
                           valid_cnt_ff <= '0;
                        end else if (q_head.data == 8'd0) begin
                           ended_ff <= 1'b1;
                        end
                     end
                     CMD_PAT: begin
                        if (wp_ff < LW'(PATTERN_BYTES)) begin
                           stage_ff[wp_ff*8 +: 8] <= q_head.data;
                           wp_ff <= wp_ff + LW'(1);
                           if (!zseen_ff) begin
                              if (q_head.data == 8'd0) begin
                                 zseen_ff <= 1'b1;
                              end else begin
                                 len_ff <= len_ff + LW'(1);
                              end
                           end
                        end
                     end
                     CMD_END: begin
                        if (room) begin
                           count_ff <= count_ff + CW'(1);
                           if (len_ff == '0) begin
                              empty_ff <= 1'b1;
                           end
                        end
                        wp_ff    <= '0;
                        len_ff   <= '0;
                        zseen_ff <= 1'b0;
                     end
                     default: begin
                        count_ff     <= '0;
                        valid_cnt_ff <= '0;
                        wp_ff        <= '0;
                        len_ff       <= '0;
                        zseen_ff     <= 1'b0;
                        empty_ff     <= 1'b0;
                        found_ff     <= 1'b0;
                        ended_ff     <= 1'b0;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               rdp_ff   <= p_ff[AW-1:0];
               fresh_ff <= (p_ff < valid_cnt_ff);
               p_ff     <= p_ff + CW'(1);
               if (hit) begin
                  found_ff <= 1'b1;
               end
            end
            ST_DONE: begin
               if (last_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_found_ff <= found_ff || hit || empty_ff;
                  found_ff     <= 1'b0;
                  ended_ff     <= 1'b0;
                  valid_cnt_ff <= '0;
               end else begin
                  found_ff     <= found_ff || hit;
                  valid_cnt_ff <= count_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

endmodule

/* hdl/caseless_multi_pattern_matcher_core.sv */
// ---------------------------------------------------------------------------
// caseless_multi_pattern_matcher_core
// case-insensitive substring search against a loaded table of patterns
// ---------------------------------------------------------------------------
// a result is registered in the back end: for an unscanned last byte as it is
// popped from the queue, for a scanned one once the walk over the table ends
// pattern and control requests are handled as they are popped; a scanned
// message byte holds the back end until its walk ends; a two-entry queue absorbs bursts
// the receiver cannot stall; results are never held off
// synchronous reset empties the table and queue, no clearing pass is needed
module caseless_multi_pattern_matcher_core #(
   parameter int NUM_PATTERNS  = 16,
   parameter int PATTERN_BYTES = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_start,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   output logic       busy,
   output logic       rsp_valid,
   output logic       rsp_found
);
   import cmm_pkg::*;

   logic     q_empty;
   logic     q_pop;
   item_type q_head;

   cmm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_start    (req_start),
      .req_mode     (req_mode),
      .req_data_byte(req_data_byte),
      .req_last     (req_last),
      .busy         (busy),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop)
   );

   cmm_back #(
      .NUM_PATTERNS (NUM_PATTERNS),
      .PATTERN_BYTES(PATTERN_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_found(rsp_found)
   );

endmodule

/* hdl/cmm_checker.sv */
// ---------------------------------------------------------------------------
// cmm_checker
// port-level checks on the matcher, bound to the top level
// ---------------------------------------------------------------------------
`include "caseless_multi_pattern_matcher_core_defines.svh"

module cmm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_start,
   input logic [1:0] req_mode,
   input logic       req_last,
   input logic       busy,
   input logic       rsp_valid
);
   import cmm_pkg::*;

   // no result right out of reset
   `CMM_ASSERT_ALWAYS(a_no_rsp_after_reset, $past(reset) |-> !rsp_valid)

   // queue is not full right out of reset
   `CMM_ASSERT_ALWAYS(a_idle_after_reset, $past(reset) |-> !busy)

   // queue only fills through an accepted request
   `CMM_ASSERT(a_busy_needs_push, $rose(busy) |-> $past(req_start))

   // a result right out of reset must follow an accepted last message request
   `CMM_ASSERT(a_rsp_source, (rsp_valid && $past(reset, 2)) |-> $past(!busy && req_start)
      && ($past(req_mode) == CMD_MSG) && $past(req_last))

endmodule

bind caseless_multi_pattern_matcher_core cmm_checker u_cmm_checker (
   .clock    (clock),
   .reset    (reset),
   .req_start(req_start),
   .req_mode (req_mode),
   .req_last (req_last),
   .busy     (busy),
   .rsp_valid(rsp_valid)
);
